// ===== src/replication_log_ring_tracker_core_defines.svh =====
// Assertion macros for the replication log ring tracker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef REPLICATION_LOG_RING_TRACKER_CORE_DEFINES_SVH
`define REPLICATION_LOG_RING_TRACKER_CORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define RLRT_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define RLRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rlrt_pkg.sv =====
package rlrt_pkg;

	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int BLOCK_W    = 31;
	localparam int ACK_W      = 11;
	localparam int LIMIT_W    = 11;
	localparam int RCOUNT_W   = 4;
	localparam int CREDIT_W   = 11;
	localparam int RPL_IDX_W  = 5;
	localparam int ACTIVE_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SEND = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ACK  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DISP = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CMPL = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLICA_COUNT = 2'd1;

	localparam logic [LIMIT_W-1:0]  CHUNK_LIMIT_RESET   = 11'd500;
	localparam logic [RCOUNT_W-1:0] REPLICA_COUNT_RESET = 4'd1;
	localparam logic [CREDIT_W-1:0] CREDIT_MAX          = 11'd2047;

	typedef struct packed {
		logic                 start;
		logic [RPL_IDX_W-1:0] replica;
		logic [ACK_W-1:0]     count;
		logic [ACTIVE_W-1:0]  active;
	} ack_req_t;

endpackage

// ===== src/rlrt_if.sv =====
interface rlrt_req_if #(
	parameter int SLOT_W = 10,
	parameter int RPL_W  = 3
);
	import rlrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [BLOCK_W-1:0]  block_id;
	logic [RPL_W-1:0]    replica;
	logic [ACK_W-1:0]    ack_count;
	logic [SLOT_W-1:0]   done_slot;

	modport source (output valid, cmd, block_id, replica, ack_count, done_slot, input ready);
	modport sink (input valid, cmd, block_id, replica, ack_count, done_slot, output ready);
endinterface

interface rlrt_rsp_if #(
	parameter int SLOT_W = 10,
	parameter int CNT_W  = 11
);
	import rlrt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0]    outstanding;
	logic [SLOT_W-1:0]   send_start;
	logic [CNT_W-1:0]    send_size;
	logic [CNT_W-1:0]    stable_added;
	logic [SLOT_W-1:0]   dispatch_slot;
	logic [BLOCK_W-1:0]  dispatch_block;
	logic [CNT_W-1:0]    retired;
	logic                synced;

	modport source (output valid, status, outstanding, send_start, send_size, stable_added,
		dispatch_slot, dispatch_block, retired, synced, input ready);
	modport sink (input valid, status, outstanding, send_start, send_size, stable_added,
		dispatch_slot, dispatch_block, retired, synced, output ready);
endinterface

interface rlrt_cfg_if;
	import rlrt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rlrt_ack_unit.sv =====
module rlrt_ack_unit #(
	parameter int MAX_REPLICAS = 8,
	parameter int CW           = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlrt_pkg::ack_req_t   req,
	input  logic [CW-1:0]        unstable,
	output logic                 done,
	output logic [CW-1:0]        added
);
	import rlrt_pkg::*;

	localparam int RW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
	localparam int AW = $clog2(MAX_REPLICAS + 1);
	localparam int XW = (CW > CREDIT_W) ? CW : CREDIT_W;

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_ADD  = 3'd1;
	localparam logic [2:0] A_MIN  = 3'd2;
	localparam logic [2:0] A_CAP  = 3'd3;
	localparam logic [2:0] A_SUB  = 3'd4;
	localparam logic [2:0] A_FIN  = 3'd5;

	logic [2:0]             state_q;
	logic [RW-1:0]          rep_q;
	logic [ACK_W-1:0]       cnt_q;
	logic [AW-1:0]          n_q;
	logic [AW-1:0]          iss_q;
	logic                   rv_q;
	logic [RW-1:0]          wa_q;
	logic [CREDIT_W-1:0]    min_q;
	logic [CREDIT_W-1:0]    m_q;

	logic [CREDIT_W-1:0]    credit_mem [MAX_REPLICAS];
	logic [MAX_REPLICAS-1:0] cvalid_q;
	logic [CREDIT_W-1:0]    rd_q;
	logic                   rd_valid_q;

	logic                   mem_we;
	logic [RW-1:0]          mem_wa;
	logic [CREDIT_W-1:0]    mem_wd;
	logic [RW-1:0]          mem_ra;
	logic [CREDIT_W-1:0]    cred;
	logic [CREDIT_W:0]      sum;
	logic [CREDIT_W-1:0]    sat;
	logic                   issue;
	logic [XW-1:0]          min_x;
	logic [XW-1:0]          un_x;
	logic [XW-1:0]          cap_x;
	logic [XW-1:0]          m_x;
	logic [CREDIT_W-1:0]    m_next;

	// Entries never written since reset read as zero credit.
	assign cred  = rd_valid_q ? rd_q : '0;
	assign sum   = (CREDIT_W + 1)'(cred) + (CREDIT_W + 1)'(cnt_q);
	assign sat   = sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
	assign issue = iss_q < n_q;

	assign min_x  = XW'(min_q);
	assign un_x   = XW'(unstable);
	assign cap_x  = (min_x < un_x) ? min_x : un_x;
	assign m_next = cap_x[CREDIT_W-1:0];
	assign m_x    = XW'(m_q);
	assign added  = m_x[CW-1:0];
	assign done   = state_q == A_FIN;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = rep_q;
		mem_wd = sat;
		mem_ra = iss_q[RW-1:0];
		unique case (state_q)
			A_IDLE: begin
				mem_ra = req.replica[RW-1:0];
			end
			A_ADD: begin
				mem_we = 1'b1;
			end
			A_SUB: begin
				mem_we = rv_q;
				mem_wa = wa_q;
				mem_wd = cred - m_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			credit_mem[mem_wa] <= mem_wd;
		end
		rd_q <= credit_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q   <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= cvalid_q[mem_ra];
			if (mem_we) begin
				cvalid_q[mem_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			rep_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
			iss_q   <= '0;
			rv_q    <= 1'b0;
			wa_q    <= '0;
			min_q   <= CREDIT_MAX;
			m_q     <= '0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						rep_q   <= req.replica[RW-1:0];
						cnt_q   <= req.count;
						n_q     <= req.active[AW-1:0];
						state_q <= A_ADD;
					end
				end
				A_ADD: begin
					iss_q   <= '0;
					rv_q    <= 1'b0;
					min_q   <= CREDIT_MAX;
					state_q <= A_MIN;
				end
				A_MIN: begin
					if (issue) begin
						iss_q <= iss_q + AW'(1);
					end
					rv_q <= issue;
					if (rv_q && (cred < min_q)) begin
						min_q <= cred;
					end
					if (!issue && !rv_q) begin
						state_q <= A_CAP;
					end
				end
				A_CAP: begin
					m_q     <= m_next;
					iss_q   <= '0;
					rv_q    <= 1'b0;
					state_q <= (m_next == '0) ? A_FIN : A_SUB;
				end
				A_SUB: begin
					if (issue) begin
						iss_q <= iss_q + AW'(1);
						wa_q  <= iss_q[RW-1:0];
					end
					rv_q <= issue;
					if (!issue && !rv_q) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/replication_log_ring_tracker_core.sv =====
// Ring of DEPTH block ids walked by a send, a stable and a retire tail. One command is
// taken at a time and yields one result transfer; a new command is taken while the last
// result still waits. An ack reads the credit memory once per active replica for the
// minimum and, when some entry becomes stable, once more per replica to subtract it,
// and a complete walks the retired entries one after another through the single read
// port of the ring memory. A result that is still held back by the receiver stalls the
// next result for as long as it waits. The ring memory holds each id with its done mark
// and needs no clearing pass after reset, since every add writes its slot before any
// other command can read it. Configuration writes are accepted in any cycle and must
// only be issued while the block is idle.
`include "replication_log_ring_tracker_core_defines.svh"

module replication_log_ring_tracker_core #(
	parameter int DEPTH        = 1024,
	parameter int MAX_REPLICAS = 8
) (
	input logic        clk,
	input logic        arst_n,
	rlrt_req_if.sink   req,
	rlrt_rsp_if.source rsp,
	rlrt_cfg_if.sink   cfg
);
	import rlrt_pkg::*;

	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
	localparam int XW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_ACK  = 3'd2;
	localparam logic [2:0] ST_DISP = 3'd3;
	localparam logic [2:0] ST_MARK = 3'd4;
	localparam logic [2:0] ST_WALK = 3'd5;
	localparam logic [2:0] ST_RESP = 3'd6;

	logic [2:0]          state_q;

	logic [CMD_W-1:0]    cmd_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [RW-1:0]       replica_q;
	logic [ACK_W-1:0]    ack_q;
	logic [SW-1:0]       slot_q;

	logic [SW-1:0]       head_q;
	logic [SW-1:0]       send_tail_q;
	logic [SW-1:0]       stable_tail_q;
	logic [SW-1:0]       retire_tail_q;
	logic [CW-1:0]       send_pending_q;
	logic [CW-1:0]       stable_pending_q;
	logic [CW-1:0]       in_process_q;
	logic [CW-1:0]       occupancy_q;
	logic [LIMIT_W-1:0]  chunk_limit_q;
	logic [RCOUNT_W-1:0] replica_count_q;

	logic [STATUS_W-1:0] status_q;
	logic [SW-1:0]       send_start_q;
	logic [CW-1:0]       send_size_q;
	logic [CW-1:0]       stable_added_q;
	logic [SW-1:0]       disp_slot_q;
	logic [BLOCK_W-1:0]  disp_block_q;
	logic [CW-1:0]       retired_q;
	logic                fwd_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CW-1:0]       out_outstanding_q;
	logic [SW-1:0]       out_send_start_q;
	logic [CW-1:0]       out_send_size_q;
	logic [CW-1:0]       out_stable_added_q;
	logic [SW-1:0]       out_disp_slot_q;
	logic [BLOCK_W-1:0]  out_disp_block_q;
	logic [CW-1:0]       out_retired_q;
	logic                out_synced_q;

	logic [BLOCK_W:0]    ring_mem [DEPTH];
	logic [BLOCK_W:0]    ring_rd_q;
	logic                ring_we;
	logic [SW-1:0]       ring_wa;
	logic [BLOCK_W:0]    ring_wd;
	logic [SW-1:0]       ring_ra;

	logic [LIMIT_W-1:0]  lim;
	logic [XW-1:0]       pend_x;
	logic [XW-1:0]       lim_x;
	logic [XW-1:0]       room_x;
	logic [XW-1:0]       size_x;
	logic [XW-1:0]       tail_x;
	logic [SW-1:0]       send_next;
	logic [XW-1:0]       dist_x;
	logic                cmpl_ok;
	logic                full;
	logic [ACTIVE_W-1:0] active;
	logic                replica_ok;
	logic                walk_go;
	logic                out_load;

	ack_req_t            ack_req;
	logic                ack_done;
	logic [CW-1:0]       ack_added;
	logic [CW-1:0]       unstable;

	function automatic logic [SW-1:0] ring_inc(input logic [SW-1:0] p);
		logic [SW-1:0] r;
		r = (p == SW'(DEPTH - 1)) ? '0 : p + SW'(1);
		return r;
	endfunction

	assign req.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;

	assign full       = occupancy_q == CW'(DEPTH);
	assign unstable   = occupancy_q - in_process_q - stable_pending_q - send_pending_q;
	assign walk_go    = (in_process_q != '0) && (ring_rd_q[BLOCK_W] || fwd_q);
	assign out_load   = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	always_comb begin
		if (replica_count_q == '0) begin
			active = ACTIVE_W'(1);
		end else if (32'(replica_count_q) > MAX_REPLICAS) begin
			active = ACTIVE_W'(MAX_REPLICAS);
		end else begin
			active = ACTIVE_W'(replica_count_q);
		end
		replica_ok = ACTIVE_W'(replica_q) < active;
	end

	always_comb begin
		lim    = (chunk_limit_q == '0) ? LIMIT_W'(1) : chunk_limit_q;
		pend_x = XW'(send_pending_q);
		lim_x  = XW'(lim);
		size_x = (pend_x < lim_x) ? pend_x : lim_x;
		room_x = XW'(DEPTH) - XW'(send_tail_q);
		if (size_x > room_x) begin
			size_x = room_x;
		end
		tail_x    = XW'(send_tail_q) + size_x;
		send_next = (tail_x == XW'(DEPTH)) ? '0 : tail_x[SW-1:0];
		dist_x    = XW'(slot_q) + XW'(DEPTH) - XW'(retire_tail_q);
		if (dist_x >= XW'(DEPTH)) begin
			dist_x = dist_x - XW'(DEPTH);
		end
		cmpl_ok = (XW'(slot_q) < XW'(DEPTH)) && (dist_x < XW'(in_process_q));
	end

	always_comb begin
		ring_we = 1'b0;
		ring_wa = head_q;
		ring_wd = {1'b0, block_q};
		ring_ra = stable_tail_q;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q == CMD_ADD) begin
					ring_we = !full;
				end
				if (cmd_q == CMD_CMPL) begin
					ring_ra = slot_q;
				end
			end
			ST_MARK: begin
				ring_we = 1'b1;
				ring_wa = slot_q;
				ring_wd = {1'b1, ring_rd_q[BLOCK_W-1:0]};
				ring_ra = retire_tail_q;
			end
			ST_WALK: begin
				ring_ra = ring_inc(retire_tail_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		ring_rd_q <= ring_mem[ring_ra];
	end

	assign ack_req.start   = (state_q == ST_EXEC) && (cmd_q == CMD_ACK) && replica_ok;
	assign ack_req.replica = RPL_IDX_W'(replica_q);
	assign ack_req.count   = ack_q;
	assign ack_req.active  = active;

	rlrt_ack_unit #(
		.MAX_REPLICAS(MAX_REPLICAS),
		.CW          (CW)
	) u_ack (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ack_req),
		.unstable(unstable),
		.done    (ack_done),
		.added   (ack_added)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q   <= CHUNK_LIMIT_RESET;
			replica_count_q <= REPLICA_COUNT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CHUNK_LIMIT:   chunk_limit_q   <= cfg.data[LIMIT_W-1:0];
				CFG_REPLICA_COUNT: replica_count_q <= cfg.data[RCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			cmd_q            <= '0;
			block_q          <= '0;
			replica_q        <= '0;
			ack_q            <= '0;
			slot_q           <= '0;
			head_q           <= '0;
			send_tail_q      <= '0;
			stable_tail_q    <= '0;
			retire_tail_q    <= '0;
			send_pending_q   <= '0;
			stable_pending_q <= '0;
			in_process_q     <= '0;
			occupancy_q      <= '0;
			status_q         <= STATUS_OK;
			send_start_q     <= '0;
			send_size_q      <= '0;
			stable_added_q   <= '0;
			disp_slot_q      <= '0;
			disp_block_q     <= '0;
			retired_q        <= '0;
			fwd_q            <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						cmd_q     <= req.cmd;
						block_q   <= req.block_id;
						replica_q <= req.replica;
						ack_q     <= req.ack_count;
						slot_q    <= req.done_slot;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					status_q       <= STATUS_OK;
					send_start_q   <= '0;
					send_size_q    <= '0;
					stable_added_q <= '0;
					disp_slot_q    <= '0;
					disp_block_q   <= '0;
					retired_q      <= '0;
					state_q        <= ST_RESP;
					case (cmd_q)
						CMD_ADD: begin
							if (full) begin
								status_q <= STATUS_FULL;
							end else begin
								head_q         <= ring_inc(head_q);
								send_pending_q <= send_pending_q + CW'(1);
								occupancy_q    <= occupancy_q + CW'(1);
							end
						end
						CMD_SEND: begin
							if (send_pending_q == '0) begin
								status_q <= STATUS_NONE;
							end else begin
								send_start_q   <= send_tail_q;
								send_size_q    <= size_x[CW-1:0];
								send_tail_q    <= send_next;
								send_pending_q <= send_pending_q - size_x[CW-1:0];
							end
						end
						CMD_ACK: begin
							if (replica_ok) begin
								state_q <= ST_ACK;
							end else begin
								status_q <= STATUS_NONE;
							end
						end
						CMD_DISP: begin
							if (stable_pending_q == '0) begin
								status_q <= STATUS_NONE;
							end else begin
								state_q <= ST_DISP;
							end
						end
						CMD_CMPL: begin
							if (cmpl_ok) begin
								state_q <= ST_MARK;
							end else begin
								status_q <= STATUS_NONE;
							end
						end
						default: begin
							status_q <= STATUS_NONE;
						end
					endcase
				end
				ST_ACK: begin
					if (ack_done) begin
						stable_pending_q <= stable_pending_q + ack_added;
						stable_added_q   <= ack_added;
						state_q          <= ST_RESP;
					end
				end
				ST_DISP: begin
					disp_slot_q      <= stable_tail_q;
					disp_block_q     <= ring_rd_q[BLOCK_W-1:0];
					stable_tail_q    <= ring_inc(stable_tail_q);
					stable_pending_q <= stable_pending_q - CW'(1);
					in_process_q     <= in_process_q + CW'(1);
					state_q          <= ST_RESP;
				end
				ST_MARK: begin
					// The mark is written in this cycle, so a read of the same slot
					// returns the old word and the new mark is forwarded.
					fwd_q   <= slot_q == retire_tail_q;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					fwd_q <= 1'b0;
					if (walk_go) begin
						retire_tail_q <= ring_inc(retire_tail_q);
						in_process_q  <= in_process_q - CW'(1);
						occupancy_q   <= occupancy_q - CW'(1);
						retired_q     <= retired_q + CW'(1);
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q       <= status_q;
			out_outstanding_q  <= occupancy_q;
			out_send_start_q   <= send_start_q;
			out_send_size_q    <= send_size_q;
			out_stable_added_q <= stable_added_q;
			out_disp_slot_q    <= disp_slot_q;
			out_disp_block_q   <= disp_block_q;
			out_retired_q      <= retired_q;
			out_synced_q       <= occupancy_q == '0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.outstanding    = out_outstanding_q;
	assign rsp.send_start     = out_send_start_q;
	assign rsp.send_size      = out_send_size_q;
	assign rsp.stable_added   = out_stable_added_q;
	assign rsp.dispatch_slot  = out_disp_slot_q;
	assign rsp.dispatch_block = out_disp_block_q;
	assign rsp.retired        = out_retired_q;
	assign rsp.synced         = out_synced_q;

	`RLRT_ASSERT_HOLDS(a_counts_fit, (XW'(in_process_q) + XW'(stable_pending_q) + XW'(send_pending_q)) <= XW'(occupancy_q), "pending counts exceed occupancy")
	`RLRT_ASSERT_HOLDS(a_ack_done_in_ack, !ack_done || (state_q == ST_ACK), "ack unit finished outside an ack")
	`RLRT_ASSERT_NEXT(a_walk_retires, (state_q == ST_WALK) && walk_go, occupancy_q == $past(occupancy_q) - CW'(1), "retire step did not lower occupancy")
	`RLRT_ASSERT_NEXT(a_one_command, req.valid && req.ready, !req.ready, "command taken while another is in work")

endmodule
